// ===== hw/rtl/apq_pkg.sv =====
// Package for the array priority queue: request and status codes,
// sequencer states and default sizes. No dependencies.
package apq_pkg;
  localparam int DefDepth      = 8;
  localparam int DefValueWidth = 32;
  localparam int DefRankWidth  = 16;

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_DEQUEUE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;
endpackage

// ===== hw/rtl/array_priority_queue.sv =====
// Array priority queue: value and rank memories with a sequencer that
// scans, shifts and places entries one slot a cycle. Uses apq_pkg.
// Sequence: append, rejected, empty and unused requests go straight to the result;
//   insert shifts entries up, then places; dequeue scans all, then closes the gap.
// Throughput: one request at a time; the next is taken once the sequencer is idle.
// Reset: synchronous, active low; clears fill count and handshake state only.
module array_priority_queue #(
  parameter int DEPTH       = apq_pkg::DefDepth,
  parameter int VALUE_WIDTH = apq_pkg::DefValueWidth,
  parameter int RANK_WIDTH  = apq_pkg::DefRankWidth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] req_type, [33:2] in_value, [49:34] in_rank, [55:50] zero
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [33:2] out_value, [49:34] out_rank, [52:50] out_slot,
  // [56:53] fill_level, [63:57] zero
  output logic [63:0] out_tdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [VALUE_WIDTH-1:0] vmem [DEPTH];
  logic [RANK_WIDTH-1:0]  rmem [DEPTH];

  apq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic [AW-1:0] best_r, best_nxt;
  apq_pkg::req_t req_r, req_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [RANK_WIDTH-1:0]  rank_r, rank_nxt;
  logic [VALUE_WIDTH-1:0] bval_r, bval_nxt;
  logic [RANK_WIDTH-1:0]  brank_r, brank_nxt;
  logic [1:0] sts_r, sts_nxt;

  logic [63:0] obuf_r, obuf_nxt;
  logic        ovld_r, ovld_nxt;

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [RANK_WIDTH-1:0]  rd_rank;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic [RANK_WIDTH-1:0]  wr_rank;

  logic                   in_fire;
  apq_pkg::req_t          in_req;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [RANK_WIDTH-1:0]  in_rnk;
  logic [RANK_WIDTH-1:0]  key_rd, key_new, key_best;
  logic [63:0]            res;

  assign in_req  = apq_pkg::req_t'(in_tdata[1:0]);
  assign in_val  = VALUE_WIDTH'(in_tdata[33:2]);
  assign in_rnk  = RANK_WIDTH'(in_tdata[49:34]);
  assign in_fire = in_tvalid && in_tready;

  assign key_rd   = rd_rank ^ (RANK_WIDTH'(1) << (RANK_WIDTH - 1));
  assign key_new  = rank_r ^ (RANK_WIDTH'(1) << (RANK_WIDTH - 1));
  assign key_best = brank_r ^ (RANK_WIDTH'(1) << (RANK_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= wr_val;
      rmem[wr_addr] <= wr_rank;
    end
    if (rd_en) begin
      rd_val  <= vmem[rd_addr];
      rd_rank <= rmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apq_pkg::S_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
    pos_r   <= pos_nxt;
    lim_r   <= lim_nxt;
    best_r  <= best_nxt;
    req_r   <= req_nxt;
    val_r   <= val_nxt;
    rank_r  <= rank_nxt;
    bval_r  <= bval_nxt;
    brank_r <= brank_nxt;
    sts_r   <= sts_nxt;
    obuf_r  <= obuf_nxt;
  end

  assign in_tready  = (state_r == apq_pkg::S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = obuf_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    lim_nxt   = lim_r;
    best_nxt  = best_r;
    req_nxt   = req_r;
    val_nxt   = val_r;
    rank_nxt  = rank_r;
    bval_nxt  = bval_r;
    brank_nxt = brank_r;
    sts_nxt   = sts_r;
    obuf_nxt  = obuf_r;
    ovld_nxt  = ovld_r && !out_tready;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_val    = val_r;
    wr_rank   = rank_r;
    res       = '0;
    unique case (state_r)
      apq_pkg::S_IDLE: begin
        if (in_fire) begin
          req_nxt  = in_req;
          val_nxt  = in_val;
          rank_nxt = in_rnk;
          sts_nxt  = apq_pkg::ST_OK;
          bval_nxt = '0;
          brank_nxt = '0;
          best_nxt = '0;
          unique case (in_req)
            apq_pkg::REQ_APPEND: begin
              if (cnt_r == CW'(DEPTH)) begin
                sts_nxt = apq_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(cnt_r);
                wr_val  = in_val;
                wr_rank = in_rnk;
                cnt_nxt = cnt_r + CW'(1);
              end
              state_nxt = apq_pkg::S_DONE;
            end
            apq_pkg::REQ_INSERT: begin
              pos_nxt = (cnt_r == CW'(DEPTH)) ? CW'(DEPTH - 1) : cnt_r;
              if (cnt_r == CW'(DEPTH)) sts_nxt = apq_pkg::ST_DROPPED;
              if (pos_nxt == '0) begin
                state_nxt = apq_pkg::S_PLACE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(pos_nxt - CW'(1));
                state_nxt = apq_pkg::S_SHIFT;
              end
            end
            apq_pkg::REQ_DEQUEUE: begin
              if (cnt_r == '0) begin
                sts_nxt   = apq_pkg::ST_EMPTY;
                state_nxt = apq_pkg::S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                pos_nxt   = '0;
                lim_nxt   = cnt_r;
                state_nxt = apq_pkg::S_SCAN;
              end
            end
            default: state_nxt = apq_pkg::S_DONE;
          endcase
        end
      end
      apq_pkg::S_SHIFT: begin
        if (key_rd < key_new) begin
          wr_en   = 1'b1;
          wr_addr = AW'(pos_r);
          wr_val  = rd_val;
          wr_rank = rd_rank;
          pos_nxt = pos_r - CW'(1);
          if (pos_nxt == '0) begin
            state_nxt = apq_pkg::S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(pos_nxt - CW'(1));
          end
        end else begin
          state_nxt = apq_pkg::S_PLACE;
        end
      end
      apq_pkg::S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos_r);
        if (sts_r != apq_pkg::ST_DROPPED) cnt_nxt = cnt_r + CW'(1);
        state_nxt = apq_pkg::S_DONE;
      end
      apq_pkg::S_SCAN: begin
        if (req_r == apq_pkg::REQ_DEQUEUE) begin
          if (pos_r == '0 || key_rd > key_best) begin
            best_nxt  = AW'(pos_r);
            bval_nxt  = rd_val;
            brank_nxt = rd_rank;
          end
          if (pos_r + CW'(1) < lim_r) begin
            pos_nxt = pos_r + CW'(1);
            rd_en   = 1'b1;
            rd_addr = AW'(pos_nxt);
          end else begin
            req_nxt = apq_pkg::REQ_NONE;
            pos_nxt = CW'(best_nxt);
            if (CW'(best_nxt) + CW'(1) < lim_r) begin
              rd_en   = 1'b1;
              rd_addr = AW'(CW'(best_nxt) + CW'(1));
            end else begin
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = apq_pkg::S_DONE;
            end
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(pos_r);
          wr_val  = rd_val;
          wr_rank = rd_rank;
          pos_nxt = pos_r + CW'(1);
          if (pos_nxt + CW'(1) < lim_r) begin
            rd_en   = 1'b1;
            rd_addr = AW'(pos_nxt + CW'(1));
          end else begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = apq_pkg::S_DONE;
          end
        end
      end
      apq_pkg::S_DONE: begin
        if (!ovld_r || out_tready) begin
          res[1:0]   = sts_r;
          res[33:2]  = 32'(bval_r);
          res[49:34] = 16'(brank_r);
          res[52:50] = 3'(best_r);
          res[56:53] = 4'(cnt_r);
          obuf_nxt  = res;
          ovld_nxt  = 1'b1;
          state_nxt = apq_pkg::S_IDLE;
        end
      end
      default: state_nxt = apq_pkg::S_IDLE;
    endcase
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("fill count above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == apq_pkg::S_IDLE)
    else $error("accept while busy");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == apq_pkg::S_DONE |=> out_tvalid) else $error("result lost");
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apq_pkg::S_DONE && sts_r == apq_pkg::ST_FULL) |-> cnt_r == CW'(DEPTH))
    else $error("full reject below depth");
endmodule
